// ===== rtl/core/adll_pkg.sv =====
// Package for the array doubly linked list core: codes, widths and state type.
// No dependencies.
`timescale 1ns / 1ps
package adll_pkg;
	localparam int NodesDefault     = 64;
	localparam int ValueBitsDefault = 32;
	localparam int LinkW            = 7;
	localparam logic [LinkW-1:0] NullLink = 7'h7F;

	typedef enum logic [2:0] {
		ACT_INS_AFTER  = 3'd0,
		ACT_INS_BEFORE = 3'd1,
		ACT_DELETE     = 3'd2,
		ACT_SEARCH     = 3'd3,
		ACT_SLOT_OF    = 3'd4,
		ACT_POS_OF     = 3'd5,
		ACT_BAD6       = 3'd6,
		ACT_BAD7       = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FULL        = 3'd1,
		ST_RANGE       = 3'd2,
		ST_NOT_IN_LIST = 3'd3,
		ST_NOT_FOUND   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_EXEC, S_WR1, S_WR2, S_WALK, S_WALKD, S_OUT
	} state_t;
endpackage

// ===== rtl/core/adll_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module adll_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/array_doubly_linked_list_core.sv =====
// Array doubly linked list core: list state in three node RAMs and a sequencer.
// Depends on adll_pkg and adll_ram.
`timescale 1ns / 1ps
// After reset the core builds the free chain in S_INIT and accepts no item meanwhile.
// An insert or delete reads the addressed node in S_RD, decides and reads the front of
// the free chain in S_EXEC, then writes the links in S_WR1 and S_WR2 and raises m_tvalid
// from S_OUT. An item refused with a status, or an unknown action, skips S_WR2. Search
// and the two lookups walk the list one node per cycle, one RAM read per node; a search
// or a miss walks the whole list. One item is in work at a time; the result sits in an
// output register until taken, and the next item can be accepted in the cycle after that.
module array_doubly_linked_list_core
	import adll_pkg::*;
#(
	parameter int NODES      = NodesDefault,
	parameter int VALUE_BITS = ValueBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], node[8:3], value[40:9], lpos[46:41]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], slot[8:3], position[14:9], value_out[46:15],
	// match_count[53:47], node_count[60:54]
	output logic [63:0] m_tdata
);
	localparam int AW = $clog2(NODES);

	state_t state_q, state_d;

	action_t            act_q;
	logic [5:0]         ni_q, li_q;
	logic [VALUE_BITS-1:0] val_q;

	logic [LinkW-1:0] head_q, tail_q, free_q, cnt_q;
	logic [LinkW-1:0] cur_q, new_q, nx_q, pv_q, steps_q;
	logic [6:0]       match_q;
	logic [5:0]       fslot_q, fpos_q;
	logic [2:0]       st_q;
	logic [5:0]       slot_q, pos_q;
	logic [31:0]      vout_q;
	logic             out_v_q;
	logic             abort_q, was_empty_q;

	// RAM ports
	logic we_n, we_p, we_v;
	logic [AW-1:0] wa_n, wa_p, wa_v, ra_n, ra_p, ra_v;
	logic [LinkW-1:0] wd_n, wd_p, rd_n, rd_p;
	logic [VALUE_BITS-1:0] wd_v, rd_v;

	adll_ram #(.Width(LinkW), .Depth(NODES)) u_next (.clk, .we(we_n), .waddr(wa_n),
		.wdata(wd_n), .raddr(ra_n), .rdata(rd_n));
	adll_ram #(.Width(LinkW), .Depth(NODES)) u_prev (.clk, .we(we_p), .waddr(wa_p),
		.wdata(wd_p), .raddr(ra_p), .rdata(rd_p));
	adll_ram #(.Width(VALUE_BITS), .Depth(NODES)) u_val (.clk, .we(we_v), .waddr(wa_v),
		.wdata(wd_v), .raddr(ra_v), .rdata(rd_v));

	logic [5:0] in_ni, in_li;
	logic [2:0] in_act;
	logic [31:0] in_val;
	assign in_act = s_tdata[2:0];
	assign in_ni  = s_tdata[8:3];
	assign in_val = s_tdata[40:9];
	assign in_li  = s_tdata[46:41];

	logic [31:0] rd_sext;
	assign rd_sext = 32'(signed'(rd_v));

	logic ni_ok, nx_ok, pv_ok, cur_ok, ni_in, is_ins;
	assign ni_ok  = {1'b0, ni_q} < LinkW'(NODES);
	assign is_ins = (act_q == ACT_INS_AFTER) || (act_q == ACT_INS_BEFORE);
	// Valid in S_EXEC, when the link RAMs hold the addressed node.
	assign ni_in  = ni_ok && head_q != NullLink && ({1'b0, ni_q} == head_q || rd_p != NullLink);
	assign nx_ok  = nx_q < LinkW'(NODES);
	assign pv_ok  = pv_q < LinkW'(NODES);
	assign cur_ok = cur_q < LinkW'(NODES);

	logic accept;
	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b0, cnt_q, match_q, vout_q, pos_q, slot_q, st_q};

	// The walk stays in S_WALK while nodes remain and nothing has stopped it.
	logic walk_more, walk_hit, walk_stop;
	assign walk_more = cur_ok && steps_q < LinkW'(NODES);
	assign walk_hit  = (act_q == ACT_SLOT_OF && steps_q == {1'b0, li_q}) ||
		(act_q == ACT_POS_OF && cur_q == {1'b0, ni_q});
	assign walk_stop = !walk_more || (act_q != ACT_SEARCH && walk_hit);

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:  if (cur_q == LinkW'(NODES - 1)) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = S_RD;
			S_RD: begin
				if (act_q == ACT_SEARCH || act_q == ACT_SLOT_OF || act_q == ACT_POS_OF)
					state_d = S_WALK;
				else state_d = S_EXEC;
			end
			S_EXEC:  state_d = S_WR1;
			S_WR1:   state_d = abort_q ? S_OUT : S_WR2;
			S_WR2:   state_d = S_OUT;
			S_WALK:  state_d = walk_stop ? S_WALKD : S_WALK;
			S_WALKD: state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM access control
	always_comb begin
		we_n = 1'b0; we_p = 1'b0; we_v = 1'b0;
		wa_n = '0; wa_p = '0; wa_v = '0;
		wd_n = NullLink; wd_p = NullLink; wd_v = val_q;
		ra_n = ni_q[AW-1:0]; ra_p = ni_q[AW-1:0]; ra_v = ni_q[AW-1:0];
		unique case (state_q)
			S_INIT: begin
				we_n = 1'b1; we_p = 1'b1;
				wa_n = cur_q[AW-1:0]; wa_p = cur_q[AW-1:0];
				wd_n = (cur_q == LinkW'(NODES - 1)) ? NullLink : cur_q + 7'd1;
			end
			S_RD: begin
				// Walks start at the head; the other actions read the addressed node.
				if (act_q == ACT_SEARCH || act_q == ACT_SLOT_OF || act_q == ACT_POS_OF) begin
					ra_n = head_q[AW-1:0]; ra_v = head_q[AW-1:0];
				end
			end
			S_EXEC: begin
				// The successor of the free chain's front is then ready in S_WR1.
				ra_n = free_q[AW-1:0];
			end
			S_WALK: begin
				ra_n = rd_n[AW-1:0]; ra_v = rd_n[AW-1:0];
			end
			S_WR1: if (!abort_q) begin
				if (act_q == ACT_DELETE) begin
					we_n = 1'b1; wa_n = ni_q[AW-1:0]; wd_n = free_q;
					we_p = 1'b1; wa_p = ni_q[AW-1:0]; wd_p = NullLink;
				end else begin
					we_v = 1'b1; wa_v = new_q[AW-1:0];
					we_n = 1'b1; wa_n = new_q[AW-1:0];
					we_p = 1'b1; wa_p = new_q[AW-1:0];
					if (was_empty_q) begin
						wd_n = NullLink; wd_p = NullLink;
					end else if (act_q == ACT_INS_AFTER) begin
						wd_n = nx_q; wd_p = {1'b0, ni_q};
					end else begin
						wd_n = {1'b0, ni_q}; wd_p = pv_q;
					end
				end
			end
			S_WR2: begin
				if (act_q == ACT_DELETE) begin
					we_n = pv_ok; wa_n = pv_q[AW-1:0]; wd_n = nx_q;
					we_p = nx_ok; wa_p = nx_q[AW-1:0]; wd_p = pv_q;
				end else if (!was_empty_q) begin
					if (act_q == ACT_INS_AFTER) begin
						we_n = 1'b1; wa_n = ni_q[AW-1:0]; wd_n = new_q;
						we_p = nx_ok; wa_p = nx_q[AW-1:0]; wd_p = new_q;
					end else begin
						we_p = 1'b1; wa_p = ni_q[AW-1:0]; wd_p = new_q;
						we_n = pv_ok; wa_n = pv_q[AW-1:0]; wd_n = new_q;
					end
				end
			end
			default: ;
		endcase
		// The walk reads from cur_q's successor, held in rd_n; the first read was the head.
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cur_q   <= '0;
			head_q  <= NullLink;
			tail_q  <= NullLink;
			free_q  <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
			abort_q <= 1'b0;
			was_empty_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) out_v_q <= 1'b0;
			state_q <= state_d;
			unique case (state_q)
				S_INIT: cur_q <= cur_q + 7'd1;
				S_IDLE: if (accept) begin
					act_q <= action_t'(in_act);
					ni_q  <= in_ni;
					li_q  <= in_li;
					val_q <= VALUE_BITS'(signed'(in_val));
					abort_q <= 1'b0;
				end
				S_RD: begin
					cur_q   <= head_q;
					steps_q <= '0;
					match_q <= '0;
					fslot_q <= '0;
					fpos_q  <= '0;
					st_q    <= ST_OK;
					slot_q  <= '0;
					pos_q   <= '0;
					vout_q  <= '0;
				end
				S_EXEC: begin
					nx_q  <= rd_n;
					pv_q  <= rd_p;
					new_q <= free_q;
					was_empty_q <= head_q == NullLink;
					if (act_q == ACT_BAD6 || act_q == ACT_BAD7 || !ni_ok) begin
						st_q <= ST_RANGE; abort_q <= 1'b1;
					end else if (is_ins && head_q == NullLink) begin
						slot_q <= free_q[5:0];
					end else if (!ni_in) begin
						st_q <= ST_NOT_IN_LIST; abort_q <= 1'b1;
					end else if (is_ins && free_q == NullLink) begin
						st_q <= ST_FULL; abort_q <= 1'b1;
					end else if (is_ins) begin
						slot_q <= free_q[5:0];
					end else begin
						slot_q <= ni_q;
						vout_q <= rd_sext;
					end
				end
				S_WR1: if (!abort_q) begin
					if (act_q == ACT_DELETE) begin
						free_q <= {1'b0, ni_q};
						cnt_q  <= cnt_q - 7'd1;
						if (!pv_ok) head_q <= nx_q;
						if (!nx_ok) tail_q <= pv_q;
					end else begin
						free_q <= rd_n;   // successor of the taken free slot
						cnt_q  <= cnt_q + 7'd1;
						if (was_empty_q) begin
							head_q <= new_q; tail_q <= new_q;
						end else if (act_q == ACT_INS_AFTER) begin
							if (!nx_ok) tail_q <= new_q;
						end else if (!pv_ok) head_q <= new_q;
					end
				end
				S_WALK: begin
					if (walk_more) begin
						if (act_q == ACT_SEARCH && rd_v == val_q) begin
							if (match_q == '0) begin
								fslot_q <= cur_q[5:0]; fpos_q <= steps_q[5:0];
							end
							match_q <= match_q + 7'd1;
						end
						if (act_q != ACT_SEARCH && walk_hit) begin
							slot_q <= cur_q[5:0]; pos_q <= steps_q[5:0]; vout_q <= rd_sext;
						end
					end
					if (!walk_stop) begin
						cur_q   <= rd_n;
						steps_q <= steps_q + 7'd1;
					end else begin
						unique case (act_q)
							ACT_SEARCH: st_q <= ST_OK;
							ACT_SLOT_OF: st_q <= (walk_more && walk_hit) ? ST_OK : ST_NOT_FOUND;
							default: begin
								if (!ni_ok) st_q <= ST_RANGE;
								else st_q <= (walk_more && walk_hit) ? ST_OK : ST_NOT_IN_LIST;
								if (!ni_ok) begin
									slot_q <= '0; pos_q <= '0; vout_q <= '0;
								end
							end
						endcase
					end
				end
				S_WALKD: if (act_q == ACT_SEARCH) begin
					slot_q <= fslot_q; pos_q <= fpos_q;
					st_q   <= (match_q == '0) ? ST_NOT_FOUND : ST_OK;
				end
				S_OUT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= LinkW'(NODES))
		else $error("node count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NullLink) == (tail_q == NullLink))
		else $error("head and tail disagree on emptiness");
	assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NullLink) |-> (cnt_q == '0))
		else $error("empty list with nonzero count");
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !m_tvalid)
		else $error("input taken while result pending");
endmodule

// ===== dv/array_doubly_linked_list_core_tb.sv =====
// Testbench for array_doubly_linked_list_core: drives list actions over the stream input and
// checks each result against a behavioural model of the list held in the testbench.
// Depends on adll_pkg and the core RTL.
`timescale 1ns / 1ps
module array_doubly_linked_list_core_tb
	import adll_pkg::*;
();

	localparam int Nodes = 64;
	localparam logic [6:0] Nil = 7'h7F;
	localparam int CycleLimit = 1000000;

	// Members listed from the highest bits down, so status lands in the lowest bits.
	typedef struct packed {
		logic [6:0]  node_count;
		logic [6:0]  match_count;
		logic [31:0] value_out;
		logic [5:0]  position;
		logic [5:0]  slot;
		logic [2:0]  status;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	array_doubly_linked_list_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// Shadow copy of the list state.
	logic [31:0] mem_value [Nodes];
	logic [6:0]  nxt [Nodes];
	logic [6:0]  prv [Nodes];
	logic [6:0]  lst_head, lst_tail, free_front;
	int          lst_len;

	list_result_t pending_results [$];
	int  errors = 0;
	int  cycles = 0;
	bit  quiet_tail = 0;
	bit  slow_sink = 1;

	function automatic bit slot_linked(int s);
		return s < Nodes && (s == lst_head || prv[s] != Nil);
	endfunction

	function automatic logic [6:0] grab_free(logic [31:0] v);
		logic [6:0] n;
		n = free_front;
		free_front = nxt[n];
		mem_value[n] = v;
		lst_len++;
		return n;
	endfunction

	function automatic list_result_t apply_action(action_t act, int ni, logic [31:0] v, int li);
		list_result_t r;
		logic [6:0] n, nx, pv, cur;
		int k;
		r = '0;
		r.status = ST_OK;
		case (act)
			ACT_INS_AFTER, ACT_INS_BEFORE, ACT_DELETE: begin
				if (act != ACT_DELETE && lst_head == Nil) begin
					n = grab_free(v);
					nxt[n] = Nil;
					prv[n] = Nil;
					lst_head = n;
					lst_tail = n;
					r.slot = n[5:0];
				end else if (!slot_linked(ni)) begin
					r.status = ST_NOT_IN_LIST;
				end else if (act != ACT_DELETE && free_front == Nil) begin
					r.status = ST_FULL;
				end else if (act == ACT_INS_AFTER) begin
					n = grab_free(v);
					nx = nxt[ni];
					nxt[n] = nx;
					prv[n] = ni[6:0];
					if (nx != Nil) prv[nx] = n;
					else lst_tail = n;
					nxt[ni] = n;
					r.slot = n[5:0];
				end else if (act == ACT_INS_BEFORE) begin
					n = grab_free(v);
					pv = prv[ni];
					prv[n] = pv;
					nxt[n] = ni[6:0];
					if (pv != Nil) nxt[pv] = n;
					else lst_head = n;
					prv[ni] = n;
					r.slot = n[5:0];
				end else begin
					nx = nxt[ni];
					pv = prv[ni];
					r.value_out = mem_value[ni];
					if (pv != Nil) nxt[pv] = nx;
					else lst_head = nx;
					if (nx != Nil) prv[nx] = pv;
					else lst_tail = pv;
					nxt[ni] = free_front;
					prv[ni] = Nil;
					free_front = ni[6:0];
					lst_len--;
					r.slot = ni[5:0];
				end
			end
			ACT_SEARCH: begin
				cur = lst_head;
				for (k = 0; cur != Nil && k < Nodes; k++) begin
					if (mem_value[cur] == v) begin
						if (r.match_count == 0) begin
							r.slot = cur[5:0];
							r.position = k[5:0];
						end
						r.match_count++;
					end
					cur = nxt[cur];
				end
				if (r.match_count == 0) r.status = ST_NOT_FOUND;
			end
			ACT_SLOT_OF: begin
				r.status = ST_NOT_FOUND;
				cur = lst_head;
				for (k = 0; cur != Nil && k < Nodes; k++) begin
					if (k == li) begin
						r.status = ST_OK;
						r.slot = cur[5:0];
						r.position = li[5:0];
						r.value_out = mem_value[cur];
						break;
					end
					cur = nxt[cur];
				end
			end
			ACT_POS_OF: begin
				r.status = ST_NOT_IN_LIST;
				cur = lst_head;
				for (k = 0; cur != Nil && k < Nodes; k++) begin
					if (cur == ni) begin
						r.status = ST_OK;
						r.slot = ni[5:0];
						r.position = k[5:0];
						r.value_out = mem_value[cur];
						break;
					end
					cur = nxt[cur];
				end
			end
			default: r.status = ST_RANGE;
		endcase
		r.node_count = lst_len[6:0];
		return r;
	endfunction

	task automatic send_item(action_t act, int ni, logic [31:0] v, int li);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		s_tdata = {1'b0, li[5:0], v, ni[5:0], act};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(apply_action(act, ni, v, li));
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Values come mostly from a small pool so that searches hit and count repeats.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_live_slot();
		if (lst_len == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
		begin
			logic [6:0] cur;
			int k, hop;
			hop = $urandom_range(0, lst_len - 1);
			cur = lst_head;
			for (k = 0; k < hop; k++) cur = nxt[cur];
			return cur;
		end
	endfunction

	task automatic drain_results();
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		send_item(ACT_SEARCH, 0, 32'h0, 0);
		send_item(ACT_SLOT_OF, 0, 32'h0, 0);
		send_item(ACT_DELETE, 0, 32'h0, 0);
		send_item(ACT_POS_OF, 63, 32'h0, 0);
		send_item(ACT_INS_BEFORE, 63, 32'h8000_0000, 0);
		send_item(ACT_INS_AFTER, 0, 32'h7FFF_FFFF, 0);
		send_item(ACT_INS_BEFORE, 0, 32'hFFFF_FFFF, 0);
		send_item(ACT_INS_AFTER, 5, 32'h1, 0);
		send_item(ACT_INS_AFTER, 63, 32'h7FFF_FFFF, 0);
		send_item(ACT_SEARCH, 0, 32'h7FFF_FFFF, 0);
		send_item(ACT_SEARCH, 0, 32'h1234_5678, 0);
		send_item(ACT_SLOT_OF, 0, 32'h0, 3);
		send_item(ACT_SLOT_OF, 0, 32'h0, 63);
		send_item(ACT_POS_OF, 1, 32'h0, 0);
		send_item(ACT_POS_OF, 40, 32'h0, 0);
		send_item(ACT_BAD6, 63, 32'hFFFF_FFFF, 63);
		send_item(ACT_BAD7, 0, 32'h0, 0);
		send_item(ACT_DELETE, 2, 32'h0, 0);
		send_item(ACT_DELETE, 0, 32'h0, 0);
		send_item(ACT_DELETE, 0, 32'h0, 0);
		drain_results();
	endtask

	// Fills memory to the brim, tries one more insert, then walks the longest list.
	task automatic test_full_memory();
		while (lst_len < Nodes)
			send_item(ACT_INS_AFTER, pick_live_slot(), pick_value(), 0);
		send_item(ACT_INS_BEFORE, lst_head, 32'h5, 0);
		send_item(ACT_SLOT_OF, 0, 32'h0, 63);
		send_item(ACT_POS_OF, lst_tail, 32'h0, 0);
		send_item(ACT_SEARCH, 0, 32'h7FFF_FFFF, 0);
		drain_results();
	endtask

	task automatic test_random(int n);
		int i, ni;
		action_t act;
		for (i = 0; i < n; i++) begin
			if (i == n - 150) quiet_tail = 1;
			// Bias towards inserts when short and deletes when long.
			case ($urandom_range(0, 9))
				0, 1, 2: act = (lst_len < 48) ? ACT_INS_AFTER : ACT_DELETE;
				3, 4: act = (lst_len < 48) ? ACT_INS_BEFORE : ACT_DELETE;
				5, 6: act = ACT_DELETE;
				7: act = ACT_SEARCH;
				8: act = ($urandom_range(0, 1) != 0) ? ACT_SLOT_OF : ACT_POS_OF;
				default: act = action_t'($urandom_range(0, 7));
			endcase
			ni = pick_live_slot();
			send_item(act, ni, pick_value(), $urandom_range(0, lst_len + 2) & 63);
		end
	endtask

	// Result checking on every rising edge.
	always @(posedge clk) begin
		list_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = list_result_t'(m_tdata[60:0]);
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status); errors++;
				end
				if (got.slot != want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, got.slot); errors++;
				end
				if (got.position != want.position) begin
					$error("position: expected %0d, got %0d", want.position, got.position);
					errors++;
				end
				if (got.value_out != want.value_out) begin
					$error("value_out: expected %h, got %h", want.value_out, got.value_out);
					errors++;
				end
				if (got.match_count != want.match_count) begin
					$error("match_count: expected %0d, got %0d", want.match_count,
						got.match_count);
					errors++;
				end
				if (got.node_count != want.node_count) begin
					$error("node_count: expected %0d, got %0d", want.node_count,
						got.node_count);
					errors++;
				end
			end
		end
	end

	// Receiver stalls at random in bursts, except in the quiet tail.
	always @(negedge clk) begin
		int stall;
		if (!quiet_tail && slow_sink && $urandom_range(0, 4) == 0) begin
			stall = $urandom_range(1, 5);
			m_tready <= 1'b0;
			repeat (stall - 1) @(negedge clk);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int k;
		for (k = 0; k < Nodes; k++) begin
			mem_value[k] = '0;
			nxt[k] = (k + 1 < Nodes) ? 7'(k + 1) : Nil;
			prv[k] = Nil;
		end
		lst_head = Nil;
		lst_tail = Nil;
		free_front = '0;
		lst_len = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_memory();
		test_random(1000);
		drain_results();
		repeat (100) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
